/* rtl/msq_pkg.sv */
package msq_pkg;

    localparam int AXES_DEFAULT = 6;
    localparam int AXIS_W       = 32;
    localparam int MASK_W_MAX   = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int ROOT_W       = 24;
    localparam int RAD_W        = 48;
    localparam int REM_W        = 27;
    localparam int ROOT_STAGES  = 12;
    localparam int STAGES       = ROOT_STAGES + 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd1;

    typedef struct packed {
        logic [REM_W-1:0]  r;
        logic [ROOT_W-1:0] q;
        logic [RAD_W-1:0]  v;
    } root_t;

    function automatic root_t root_step(input root_t cur);
        root_t            nxt;
        logic [REM_W-1:0] rs;
        logic [REM_W-1:0] t;
        rs = {cur.r[REM_W-3:0], cur.v[RAD_W-1 -: 2]};
        t  = {1'b0, cur.q, 2'b01};
        if (rs >= t) begin
            nxt.r = rs - t;
            nxt.q = {cur.q[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.r = rs;
            nxt.q = {cur.q[ROOT_W-2:0], 1'b0};
        end
        nxt.v = {cur.v[RAD_W-3:0], 2'b00};
        return nxt;
    endfunction

endpackage

/* rtl/msq_axis.sv */
module msq_axis (
    input  logic                            aclk,
    input  logic [msq_pkg::STAGES-1:0]      en,
    input  logic [msq_pkg::AXIS_W-1:0]      x,
    input  logic                            sel,
    input  logic [msq_pkg::AXIS_W-1:0]      gain,
    output logic [msq_pkg::AXIS_W-1:0]      y
);

    localparam int NS = msq_pkg::STAGES;
    localparam int NR = msq_pkg::ROOT_STAGES;
    localparam int W  = msq_pkg::AXIS_W;

    logic [NS-2:0]          neg_reg;
    logic [NS-2:0]          sel_reg;
    logic [W-1:0]           x_reg    [NS-1];
    logic [W-1:0]           a_reg;
    logic [48:0]            p_reg;
    logic                   big_reg  [1:2];
    logic [56:0]            m1_reg;
    logic [55:0]            m2_reg;
    logic [W-1:0]           lmag_reg [1:NR];
    logic                   lin_reg  [3:NR];
    msq_pkg::root_t         rt_reg   [1:NR];
    logic [W-1:0]           y_reg;

    logic [W-1:0]           a_next;
    logic [63:0]            prod_next;
    logic [80:0]            sum_next;
    msq_pkg::root_t         rt_next  [1:NR];
    msq_pkg::root_t         rt_half  [1:NR];
    logic [W-1:0]           mag_next;
    logic [W-1:0]           y_next;

    always_comb begin
        a_next    = x[W-1] ? (~x + W'(1)) : x;
        prod_next = 64'(gain) * 64'(a_reg);
        sum_next  = {m1_reg, 24'b0} + 81'(m2_reg);
        for (int k = 1; k <= NR; k++) begin
            if (k == 1) begin
                rt_half[k] = msq_pkg::root_step('{r: '0, q: '0, v: {a_reg, 16'b0}});
            end else begin
                rt_half[k] = msq_pkg::root_step(rt_reg[k-1]);
            end
            rt_next[k] = msq_pkg::root_step(rt_half[k]);
        end
        mag_next = lin_reg[NR] ? lmag_reg[NR]
                               : {{(W-msq_pkg::ROOT_W){1'b0}}, rt_reg[NR].q};
        if (!sel_reg[NS-2]) begin
            y_next = x_reg[NS-2];
        end else if (gain == '0) begin
            y_next = '0;
        end else if (neg_reg[NS-2]) begin
            y_next = ~mag_next + W'(1);
        end else begin
            y_next = mag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            neg_reg[0] <= x[W-1];
            sel_reg[0] <= sel;
            x_reg[0]   <= x;
            a_reg      <= a_next;
        end
        for (int k = 1; k < NS-1; k++) begin
            if (en[k]) begin
                neg_reg[k] <= neg_reg[k-1];
                sel_reg[k] <= sel_reg[k-1];
                x_reg[k]   <= x_reg[k-1];
            end
        end
        if (en[1]) begin
            p_reg       <= prod_next[48:0];
            lmag_reg[1] <= prod_next[47:16];
            big_reg[1]  <= prod_next > 64'h0001_0000_0000_0000;
        end
        if (en[2]) begin
            m1_reg     <= p_reg[48:24] * gain;
            m2_reg     <= p_reg[23:0] * gain;
            big_reg[2] <= big_reg[1];
        end
        if (en[3]) begin
            lin_reg[3] <= !big_reg[2] && (sum_next <= (81'(1) << 48));
        end
        for (int k = 4; k <= NR; k++) begin
            if (en[k]) begin
                lin_reg[k] <= lin_reg[k-1];
            end
        end
        for (int k = 2; k <= NR; k++) begin
            if (en[k]) begin
                lmag_reg[k] <= lmag_reg[k-1];
            end
        end
        for (int k = 1; k <= NR; k++) begin
            if (en[k]) begin
                rt_reg[k] <= rt_next[k];
            end
        end
        if (en[NS-1]) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

/* rtl/masked_signed_sqrt_six_axis.sv */
// Masked signed square-root shaper for six-axis force/torque samples.
// Input channel s_*: one sample per transaction, six signed Q16.16 axes in
// s_tdata. Result channel m_*: the shaped sample in the same layout.
// Configuration: cfg_we with cfg_idx and cfg_wdata writes gain (index 0)
// or axis_mask (index 1); other indexes are ignored. Write only when idle.
// Each masked axis gives 0 when gain is zero, gain*x while gain^2*|x| <= 1,
// else sign(x)*floor(sqrt(|x|)).
// The pipeline has one input stage, twelve square-root stages of two root
// bits each (the root unit sets the depth), and one output register. It
// takes one transaction per cycle unless a stall on m_tready holds it.
// Every stage holds a valid bit and loads when it is empty or the stage after
// it is empty or moving, so bubbles close up and s_tready drops only once all stages
// hold a transaction while m_tready is low. A stall loses nothing.
// Reset clears the valid bits, gain and axis_mask.
module masked_signed_sqrt_six_axis #(
    parameter int AXES = msq_pkg::AXES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [msq_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [msq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z
    input  logic [AXES*msq_pkg::AXIS_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_force_x, out_force_y, out_force_z, out_torque_x, out_torque_y, out_torque_z
    output logic [AXES*msq_pkg::AXIS_W-1:0] m_tdata
);

    localparam int NS = msq_pkg::STAGES;
    localparam int W  = msq_pkg::AXIS_W;

    logic [W-1:0]    gain_reg;
    logic [AXES-1:0] mask_reg;
    logic [NS-1:0]   valid_reg;
    logic [NS-1:0]   rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
            mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                msq_pkg::REG_GAIN: gain_reg <= cfg_wdata;
                msq_pkg::REG_MASK: begin
                    for (int i = 0; i < AXES; i++) begin
                        mask_reg[i] <= (i < msq_pkg::MASK_W_MAX) ? cfg_wdata[i] : 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        rdy[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS-2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        msq_axis u_axis (
            .aclk (aclk),
            .en   (rdy),
            .x    (s_tdata[i*W +: W]),
            .sel  (mask_reg[i]),
            .gain (gain_reg),
            .y    (m_tdata[i*W +: W])
        );
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NS-1];

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && valid_reg == '1))
        else $error("input stalled with room in pipeline");

    a_valid_drops_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without transaction");

    a_zero_gain_all_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && gain_reg == '0 && mask_reg == '1) |-> (m_tdata == '0))
        else $error("zero gain gave non-zero masked result");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int N_AXES = 6;
    localparam int SAMPLE_W = N_AXES * msq_pkg::AXIS_W;
    localparam int AW = msq_pkg::AXIS_W;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [msq_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [msq_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [msq_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [msq_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [SAMPLE_W-1:0]            s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [SAMPLE_W-1:0]            m_tdata;

    logic [31:0]         model_gain;
    logic [5:0]          model_mask;
    logic [SAMPLE_W-1:0] shaped_q[$];
    int                  mismatches;
    int                  cycles;
    bit                  calm;

    masked_signed_sqrt_six_axis #(.AXES(N_AXES)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] shape_axis(input logic [31:0] x);
        logic [32:0]  mag_in;
        logic [127:0] prod;
        logic [63:0]  mag;
        if (model_gain == 0) return 32'd0;
        mag_in = x[31] ? (33'h1_0000_0000 - {1'b0, x}) : {1'b0, x};
        prod   = 128'(model_gain) * 128'(model_gain) * 128'(mag_in);
        if (prod <= (128'd1 << 48))
            mag = (64'(model_gain) * 64'(mag_in)) >> 16;
        else
            mag = 64'(root_floor(64'(mag_in) << 16));
        return x[31] ? (32'd0 - mag[31:0]) : mag[31:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] shape_sample(input logic [SAMPLE_W-1:0] d);
        logic [SAMPLE_W-1:0] r;
        for (int i = 0; i < N_AXES; i++)
            r[i*AW +: AW] = model_mask[i] ? shape_axis(d[i*AW +: AW])
                                          : d[i*AW +: AW];
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 34);

    always @(posedge aclk) begin
        logic [SAMPLE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shaped_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", m_tdata);
            end else begin
                want = shaped_q.pop_front();
                for (int i = 0; i < N_AXES; i++)
                    if (m_tdata[i*AW +: AW] !== want[i*AW +: AW]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("axis %0d: expected %h, got %h", i,
                                     want[i*AW +: AW], m_tdata[i*AW +: AW]);
                    end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] d);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        shaped_q.push_back(shape_sample(d));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (shaped_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [msq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == msq_pkg::REG_GAIN) model_gain = val;
        else if (idx == msq_pkg::REG_MASK) model_mask = val[5:0];
    endtask

    function automatic logic [31:0] rand_axis();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(32'h0004_0000);
            2: return 32'd0 - $urandom_range(32'h0004_0000);
            3: return $urandom_range(255) - 128;
            default: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] fill_axes(input logic [31:0] v);
        return {N_AXES{v}};
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] d;
        for (int i = 0; i < N_AXES; i++) d[i*AW +: AW] = rand_axis();
        return d;
    endfunction

    task automatic test_reset_passthrough();
        send_sample(fill_axes(32'h8000_0000));
        send_sample(fill_axes(32'h7fff_ffff));
        send_sample(rand_sample());
    endtask

    task automatic test_directed();
        logic [31:0] gains[4] = '{32'd0, 32'h0001_0000, 32'h0002_0000, 32'hffff_ffff};
        write_reg(msq_pkg::REG_MASK, 32'hffff_ffff);
        foreach (gains[k]) begin
            write_reg(msq_pkg::REG_GAIN, gains[k]);
            send_sample({32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         32'h0001_0000});
            send_sample({32'hffff_0000, 32'h0000_4000, 32'hffff_c000, 32'h0000_4001,
                         32'hffff_bfff, 32'h0000_ffff});
        end
        write_reg(REG_UNUSED_A, 32'h0);
        write_reg(REG_UNUSED_B, 32'h0);
        write_reg(msq_pkg::REG_MASK, 32'h15);
        send_sample(fill_axes(32'h0009_0000));
        write_reg(msq_pkg::REG_MASK, 32'h2a);
        send_sample(fill_axes(32'hfff7_0000));
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 4)
                0: write_reg(msq_pkg::REG_GAIN, $urandom_range(32'h0004_0000));
                1: write_reg(msq_pkg::REG_GAIN, $urandom());
                2: write_reg(msq_pkg::REG_GAIN, phase < 5 ? 32'd0 : 32'hffff_ffff);
                default: write_reg(msq_pkg::REG_GAIN, $urandom_range(32'h0000_2000));
            endcase
            write_reg(msq_pkg::REG_MASK, phase == 0 ? 32'h3f : $urandom());
            calm = (phase == 4);
            for (int n = 0; n < 62; n++) send_sample(rand_sample());
            calm = 1'b0;
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = msq_pkg::REG_GAIN;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        model_gain = 0;
        model_mask = 0;
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_passthrough();
        test_directed();
        test_random();
        wait_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
